@@ rtl/cz_pkg.sv @@
// Shared constants, types and helpers for the column z-score standardizer.
package cz_pkg;

    // Store and column geometry
    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_COLUMNS  = 64;
    localparam int SAMPLE_W     = 16;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int COL_IDX_W    = $clog2(MAX_COLUMNS);
    localparam int COL_W        = COL_IDX_W + 1;

    localparam logic [CNT_W-1:0] MAX_ELEM_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [COL_W-1:0] MAX_COL_CNT  = COL_W'(MAX_COLUMNS);

    // Accumulator and arithmetic widths
    localparam int SUM_W      = 28;
    localparam int SQ_W       = 43;
    localparam int PROD_W     = 55;
    localparam int NN_W       = 25;
    localparam int DIV_STEP_W = 6;
    localparam int MUL_STEPS  = 28;
    localparam int MCNT_W     = 5;
    localparam int SQRT_W     = 32;
    localparam int SQRT_STEPS = 16;
    localparam int SCNT_W     = 5;

    // Input modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_OVF   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_ROWS, S_ST_RD, S_ST_ACC, S_MEAN_GO, S_MEAN, S_NQ, S_SS,
        S_NN, S_VAR, S_SQRT, S_RD_ADDR, S_RD_CALC, S_RD_DIV, S_EMIT, S_EMPTY
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_ROWS_START, OP_ROWS_SAVE, OP_ST_RD,
        OP_ST_ACC, OP_MEAN_START, OP_MEAN_SAVE, OP_NQ_SAVE, OP_SS_SAVE,
        OP_NN_SAVE, OP_VAR_SAVE, OP_COL_SAVE, OP_RD_ADDR, OP_RD_CALC,
        OP_RD_QUOT, OP_EMIT, OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       in_valid;
        logic       rows_zero;
        logic       stats_ready;
        logic       row_last;
        logic       col_last;
        logic       dev_zero;
        logic       div_busy;
        logic       mul_busy;
        logic       sqrt_busy;
        logic       out_free;
    } t_sts;

    // Clamp a wide signed value into the sample range
    function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd32767;
        lo = -26'sd32768;
        if (v > hi) begin
            return 16'h7FFF;
        end else if (v < lo) begin
            return 16'h8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

@@ rtl/cz_if.sv @@
// Channel interfaces: input word, result word and configuration write.
interface cz_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic signed [15:0]          sample_value;
    modport source (output valid, mode, sample_value, input ready);
    modport sink   (input valid, mode, sample_value, output ready);
endinterface

interface cz_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          normalized_value;
    logic [11:0]                 row_index;
    logic [5:0]                  column_index;
    logic                        last;
    logic [1:0]                  status;
    modport source (output valid, normalized_value, row_index, column_index, last, status,
                    input ready);
    modport sink   (input valid, normalized_value, row_index, column_index, last, status,
                    output ready);
endinterface

interface cz_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [6:0]                  num_columns;
    modport source (output valid, num_columns, input ready);
    modport sink   (input valid, num_columns, output ready);
endinterface

@@ rtl/cz_div.sv @@
// Restoring serial divider, one quotient bit per cycle, dividend left-aligned.
module cz_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cz_pkg::PROD_W-1:0]         i_dividend,
    input  logic [cz_pkg::NN_W-1:0]           i_divisor,
    input  logic [cz_pkg::DIV_STEP_W-1:0]     i_steps,
    output logic                              o_busy,
    output logic [cz_pkg::PROD_W-1:0]         o_quot,
    output logic [cz_pkg::NN_W-1:0]           o_rem
);
    logic [cz_pkg::PROD_W-1:0]     r_q;
    logic [cz_pkg::NN_W-1:0]       r_r;
    logic [cz_pkg::NN_W-1:0]       r_d;
    logic [cz_pkg::DIV_STEP_W-1:0] r_cnt;
    logic                          r_busy;
    logic [cz_pkg::NN_W:0]         trial;
    logic [cz_pkg::NN_W:0]         diff;
    logic                          ge;

    // shift in next dividend bit, try subtract
    always_comb begin
        trial = {r_r, r_q[cz_pkg::PROD_W-1]};
        diff  = trial - {1'b0, r_d};
        ge    = (trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == cz_pkg::DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[cz_pkg::PROD_W-2:0], ge};
            r_r <= ge ? diff[cz_pkg::NN_W-1:0] : trial[cz_pkg::NN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

@@ rtl/cz_ctrl.sv @@
// Sequencer: walks loads, the per-column statistics pass and element reads.
module cz_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  cz_pkg::t_sts i_sts,
    output cz_pkg::t_cmd o_cmd
);
    cz_pkg::t_state r_state;
    cz_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cz_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state         = r_state;
        o_cmd.op        = cz_pkg::OP_NONE;
        o_cmd.in_ready  = 1'b0;
        unique case (r_state)
            cz_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    unique case (i_sts.in_mode)
                        cz_pkg::MODE_LOAD:  o_cmd.op = cz_pkg::OP_LOAD;
                        cz_pkg::MODE_CLEAR: o_cmd.op = cz_pkg::OP_CLEAR;
                        cz_pkg::MODE_READ: begin
                            o_cmd.op = cz_pkg::OP_ROWS_START;
                            n_state  = cz_pkg::S_ROWS;
                        end
                        default: o_cmd.op = cz_pkg::OP_NONE;
                    endcase
                end
            end
            cz_pkg::S_ROWS: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = cz_pkg::OP_ROWS_SAVE;
                    if (i_sts.rows_zero) begin
                        n_state = cz_pkg::S_EMPTY;
                    end else if (i_sts.stats_ready) begin
                        n_state = cz_pkg::S_RD_ADDR;
                    end else begin
                        n_state = cz_pkg::S_ST_RD;
                    end
                end
            end
            cz_pkg::S_ST_RD: begin
                o_cmd.op = cz_pkg::OP_ST_RD;
                n_state  = cz_pkg::S_ST_ACC;
            end
            cz_pkg::S_ST_ACC: begin
                o_cmd.op = cz_pkg::OP_ST_ACC;
                n_state  = i_sts.row_last ? cz_pkg::S_MEAN_GO : cz_pkg::S_ST_RD;
            end
            cz_pkg::S_MEAN_GO: begin
                o_cmd.op = cz_pkg::OP_MEAN_START;
                n_state  = cz_pkg::S_MEAN;
            end
            cz_pkg::S_MEAN: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = cz_pkg::OP_MEAN_SAVE;
                    n_state  = cz_pkg::S_NQ;
                end
            end
            cz_pkg::S_NQ: begin
                if (!i_sts.mul_busy) begin
                    o_cmd.op = cz_pkg::OP_NQ_SAVE;
                    n_state  = cz_pkg::S_SS;
                end
            end
            cz_pkg::S_SS: begin
                if (!i_sts.mul_busy) begin
                    o_cmd.op = cz_pkg::OP_SS_SAVE;
                    n_state  = cz_pkg::S_NN;
                end
            end
            cz_pkg::S_NN: begin
                if (!i_sts.mul_busy) begin
                    o_cmd.op = cz_pkg::OP_NN_SAVE;
                    n_state  = cz_pkg::S_VAR;
                end
            end
            cz_pkg::S_VAR: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = cz_pkg::OP_VAR_SAVE;
                    n_state  = cz_pkg::S_SQRT;
                end
            end
            cz_pkg::S_SQRT: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.op = cz_pkg::OP_COL_SAVE;
                    n_state  = i_sts.col_last ? cz_pkg::S_RD_ADDR : cz_pkg::S_ST_RD;
                end
            end
            cz_pkg::S_RD_ADDR: begin
                o_cmd.op = cz_pkg::OP_RD_ADDR;
                n_state  = cz_pkg::S_RD_CALC;
            end
            cz_pkg::S_RD_CALC: begin
                o_cmd.op = cz_pkg::OP_RD_CALC;
                n_state  = i_sts.dev_zero ? cz_pkg::S_EMIT : cz_pkg::S_RD_DIV;
            end
            cz_pkg::S_RD_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = cz_pkg::OP_RD_QUOT;
                    n_state  = cz_pkg::S_EMIT;
                end
            end
            cz_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = cz_pkg::OP_EMIT;
                    n_state  = cz_pkg::S_IDLE;
                end
            end
            cz_pkg::S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.op = cz_pkg::OP_EMPTY;
                    n_state  = cz_pkg::S_IDLE;
                end
            end
            default: n_state = cz_pkg::S_IDLE;
        endcase
    end

endmodule

@@ rtl/cz_dp.sv @@
// Datapath: element store, column accumulators, multiply, square root, result word.
module cz_dp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  cz_pkg::t_cmd i_cmd,
    output cz_pkg::t_sts o_sts,
    cz_in_if.sink        i_in,
    cz_out_if.source     o_out,
    cz_cfg_if.sink       i_cfg
);
    localparam int AW  = cz_pkg::ADDR_W;
    localparam int CW  = cz_pkg::CNT_W;
    localparam int KW  = cz_pkg::COL_W;
    localparam int KIW = cz_pkg::COL_IDX_W;
    localparam int PW  = cz_pkg::PROD_W;

    // memories
    logic signed [15:0] r_store    [cz_pkg::MAX_ELEMENTS];
    logic signed [15:0] r_mean_mem [cz_pkg::MAX_COLUMNS];
    logic [15:0]        r_dev_mem  [cz_pkg::MAX_COLUMNS];

    // control state
    logic [KW-1:0] r_cfg;
    logic [CW-1:0] r_load_count;
    logic          r_ovf;
    logic          r_stats_ready;
    logic [CW-1:0] r_rd_ptr;
    logic [CW-1:0] r_rd_row;
    logic [KW-1:0] r_rd_col;
    logic          r_out_valid;

    // stats pass registers
    logic [CW-1:0]                   r_rows;
    logic [CW-1:0]                   r_total;
    logic [KW-1:0]                   r_st_c;
    logic [CW-1:0]                   r_st_r;
    logic [CW-1:0]                   r_st_addr;
    logic signed [cz_pkg::SUM_W-1:0] r_s;
    logic [cz_pkg::SQ_W-1:0]         r_q;
    logic signed [15:0]              r_mean;
    logic [PW-1:0]                   r_nq;
    logic [PW-1:0]                   r_num;

    // read path registers
    logic signed [15:0] r_x;
    logic signed [15:0] r_mean_rd;
    logic [15:0]        r_dev_rd;
    logic               r_d_neg;
    logic [15:0]        r_res;

    // result word
    logic [15:0] r_o_val;
    logic [11:0] r_o_row;
    logic [5:0]  r_o_col;
    logic        r_o_last;
    logic [1:0]  r_o_sts;

    // shift-add multiplier
    logic [PW-1:0]                 r_m_acc;
    logic [PW-1:0]                 r_m_cand;
    logic [cz_pkg::SUM_W-1:0]      r_m_plier;
    logic [cz_pkg::MCNT_W-1:0]     r_m_cnt;
    logic                          r_m_busy;

    // digit-by-digit square root
    logic [cz_pkg::SQRT_W-1:0]     r_sq_v;
    logic [cz_pkg::SQRT_W-1:0]     r_sq_res;
    logic [cz_pkg::SQRT_W-1:0]     r_sq_bit;
    logic [cz_pkg::SCNT_W-1:0]     r_sq_cnt;
    logic                          r_sq_busy;

    // combinational helpers
    logic [KW-1:0]                 nc;
    logic                          accept;
    logic                          out_free;
    logic signed [31:0]            sq;
    logic [cz_pkg::SUM_W-1:0]      s_abs;
    logic signed [16:0]            d;
    logic [16:0]                   d_mag;
    logic                          div_start;
    logic [PW-1:0]                 div_dvd;
    logic [cz_pkg::NN_W-1:0]       div_dvs;
    logic [cz_pkg::DIV_STEP_W-1:0] div_steps;
    logic                          div_busy;
    logic [PW-1:0]                 div_q;
    logic [cz_pkg::NN_W-1:0]       div_r;
    logic [15:0]                   mq;
    logic signed [25:0]            q_signed;
    logic [CW-1:0]                 ptr_nxt;
    logic                          rd_last;
    logic [cz_pkg::SQRT_W-1:0]     sq_try;
    logic [AW-1:0]                 mem_raddr;

    // column count, out-of-range values clamped
    always_comb begin
        if (r_cfg == '0) begin
            nc = KW'(1);
        end else if (r_cfg > cz_pkg::MAX_COL_CNT) begin
            nc = cz_pkg::MAX_COL_CNT;
        end else begin
            nc = r_cfg;
        end
    end

    assign accept   = i_in.valid && i_cmd.in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    // arithmetic
    always_comb begin
        sq       = r_x * r_x;
        s_abs    = r_s[cz_pkg::SUM_W-1] ? cz_pkg::SUM_W'(-r_s) : r_s;
        d        = 17'(r_x) - 17'(r_mean_rd);
        d_mag    = d[16] ? 17'(-d) : 17'(d);
        mq       = div_q[15:0];
        q_signed = r_d_neg ? -$signed({1'b0, div_q[24:0]}) : $signed({1'b0, div_q[24:0]});
        ptr_nxt  = r_rd_ptr + CW'(1);
        rd_last  = (ptr_nxt == r_total);
        sq_try   = r_sq_res + r_sq_bit;
        mem_raddr = (i_cmd.op == cz_pkg::OP_ST_RD) ? r_st_addr[AW-1:0] : r_rd_ptr[AW-1:0];
    end

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        div_steps = '0;
        case (i_cmd.op)
            cz_pkg::OP_ROWS_START: begin
                div_start = 1'b1;
                div_dvd   = {r_load_count, (PW-CW)'(0)};
                div_dvs   = cz_pkg::NN_W'(nc);
                div_steps = cz_pkg::DIV_STEP_W'(CW);
            end
            cz_pkg::OP_MEAN_START: begin
                div_start = 1'b1;
                div_dvd   = {s_abs, (PW-cz_pkg::SUM_W)'(0)};
                div_dvs   = cz_pkg::NN_W'(r_rows);
                div_steps = cz_pkg::DIV_STEP_W'(cz_pkg::SUM_W);
            end
            cz_pkg::OP_NN_SAVE: begin
                div_start = 1'b1;
                div_dvd   = r_num;
                div_dvs   = r_m_acc[cz_pkg::NN_W-1:0];
                div_steps = cz_pkg::DIV_STEP_W'(PW);
            end
            cz_pkg::OP_RD_CALC: begin
                div_start = (r_dev_rd != '0);
                div_dvd   = {d_mag[15:0], 8'd0, (PW-24)'(0)};
                div_dvs   = cz_pkg::NN_W'(r_dev_rd);
                div_steps = cz_pkg::DIV_STEP_W'(24);
            end
            default: div_start = 1'b0;
        endcase
    end

    cz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // element store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cz_pkg::OP_LOAD && r_load_count < cz_pkg::MAX_ELEM_CNT) begin
            r_store[r_load_count[AW-1:0]] <= i_in.sample_value;
        end
        if (i_cmd.op == cz_pkg::OP_ST_RD || i_cmd.op == cz_pkg::OP_RD_ADDR) begin
            r_x <= r_store[mem_raddr];
        end
    end

    // per-column mean and deviation tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cz_pkg::OP_COL_SAVE) begin
            r_mean_mem[r_st_c[KIW-1:0]] <= r_mean;
            r_dev_mem[r_st_c[KIW-1:0]]  <= r_sq_res[15:0];
        end
        if (i_cmd.op == cz_pkg::OP_RD_ADDR) begin
            r_mean_rd <= r_mean_mem[r_rd_col[KIW-1:0]];
            r_dev_rd  <= r_dev_mem[r_rd_col[KIW-1:0]];
        end
    end

    // multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_busy <= 1'b0;
            r_m_cnt  <= '0;
        end else begin
            case (i_cmd.op)
                cz_pkg::OP_MEAN_SAVE, cz_pkg::OP_NQ_SAVE, cz_pkg::OP_SS_SAVE: begin
                    r_m_busy <= 1'b1;
                    r_m_cnt  <= cz_pkg::MCNT_W'(cz_pkg::MUL_STEPS);
                end
                default: begin
                    if (r_m_busy) begin
                        r_m_cnt <= r_m_cnt - 1'b1;
                        if (r_m_cnt == cz_pkg::MCNT_W'(1)) begin
                            r_m_busy <= 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cz_pkg::OP_MEAN_SAVE: begin
                r_m_acc   <= '0;
                r_m_cand  <= PW'(r_q);
                r_m_plier <= cz_pkg::SUM_W'(r_rows);
            end
            cz_pkg::OP_NQ_SAVE: begin
                r_m_acc   <= '0;
                r_m_cand  <= PW'(s_abs);
                r_m_plier <= s_abs;
            end
            cz_pkg::OP_SS_SAVE: begin
                r_m_acc   <= '0;
                r_m_cand  <= PW'(r_rows);
                r_m_plier <= cz_pkg::SUM_W'(r_rows);
            end
            default: begin
                if (r_m_busy) begin
                    if (r_m_plier[0]) begin
                        r_m_acc <= r_m_acc + r_m_cand;
                    end
                    r_m_cand  <= {r_m_cand[PW-2:0], 1'b0};
                    r_m_plier <= {1'b0, r_m_plier[cz_pkg::SUM_W-1:1]};
                end
            end
        endcase
    end

    // square root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (i_cmd.op == cz_pkg::OP_VAR_SAVE) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= cz_pkg::SCNT_W'(cz_pkg::SQRT_STEPS);
        end else if (r_sq_busy) begin
            r_sq_cnt <= r_sq_cnt - 1'b1;
            if (r_sq_cnt == cz_pkg::SCNT_W'(1)) begin
                r_sq_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cz_pkg::OP_VAR_SAVE) begin
            r_sq_v   <= div_q[cz_pkg::SQRT_W-1:0];
            r_sq_res <= '0;
            r_sq_bit <= cz_pkg::SQRT_W'(1) << (cz_pkg::SQRT_W - 2);
        end else if (r_sq_busy) begin
            if (r_sq_v >= sq_try) begin
                r_sq_v   <= r_sq_v - sq_try;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
    end

    // stats pass and read payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cz_pkg::OP_ROWS_SAVE: begin
                r_rows    <= div_q[CW-1:0];
                r_total   <= r_load_count - div_r[CW-1:0];
                r_st_c    <= '0;
                r_st_r    <= '0;
                r_st_addr <= '0;
                r_s       <= '0;
                r_q       <= '0;
            end
            cz_pkg::OP_ST_ACC: begin
                r_s       <= r_s + cz_pkg::SUM_W'(r_x);
                r_q       <= r_q + cz_pkg::SQ_W'(unsigned'(sq));
                r_st_addr <= r_st_addr + CW'(nc);
                r_st_r    <= r_st_r + CW'(1);
            end
            cz_pkg::OP_MEAN_SAVE: begin
                r_mean <= r_s[cz_pkg::SUM_W-1] ? 16'(-mq) : mq;
            end
            cz_pkg::OP_NQ_SAVE: begin
                r_nq <= r_m_acc;
            end
            cz_pkg::OP_SS_SAVE: begin
                r_num <= r_nq - r_m_acc;
            end
            cz_pkg::OP_COL_SAVE: begin
                r_st_c    <= r_st_c + KW'(1);
                r_st_r    <= '0;
                r_st_addr <= CW'(r_st_c) + CW'(1);
                r_s       <= '0;
                r_q       <= '0;
            end
            cz_pkg::OP_RD_CALC: begin
                r_d_neg <= d[16];
                r_res   <= cz_pkg::sat16(26'(d));
            end
            cz_pkg::OP_RD_QUOT: begin
                r_res <= cz_pkg::sat16(q_signed);
            end
            cz_pkg::OP_EMIT: begin
                r_o_val  <= r_res;
                r_o_row  <= r_rd_row[11:0];
                r_o_col  <= r_rd_col[5:0];
                r_o_last <= rd_last;
                r_o_sts  <= r_ovf ? cz_pkg::STS_OVF : cz_pkg::STS_OK;
            end
            cz_pkg::OP_EMPTY: begin
                r_o_val  <= '0;
                r_o_row  <= '0;
                r_o_col  <= '0;
                r_o_last <= 1'b0;
                r_o_sts  <= cz_pkg::STS_EMPTY;
            end
            default: r_o_sts <= r_o_sts;
        endcase
    end

    // result valid: set on a result write, dropped when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == cz_pkg::OP_EMIT || i_cmd.op == cz_pkg::OP_EMPTY) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // control state: counters, flags, configuration, read position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= KW'(1);
            r_load_count  <= '0;
            r_ovf         <= 1'b0;
            r_stats_ready <= 1'b0;
            r_rd_ptr      <= '0;
            r_rd_row      <= '0;
            r_rd_col      <= '0;
        end else begin
            case (i_cmd.op)
                cz_pkg::OP_LOAD: begin
                    if (r_load_count < cz_pkg::MAX_ELEM_CNT) begin
                        r_load_count <= r_load_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                cz_pkg::OP_CLEAR: begin
                    r_load_count <= '0;
                    r_ovf        <= 1'b0;
                end
                default: r_ovf <= r_ovf;
            endcase

            if (i_cfg.valid) begin
                r_cfg <= i_cfg.num_columns;
            end

            // statistics go stale on a stored load, a clear or a config write
            if (i_cfg.valid || i_cmd.op == cz_pkg::OP_CLEAR ||
                (i_cmd.op == cz_pkg::OP_LOAD && r_load_count < cz_pkg::MAX_ELEM_CNT)) begin
                r_stats_ready <= 1'b0;
            end else if (i_cmd.op == cz_pkg::OP_COL_SAVE && o_sts.col_last) begin
                r_stats_ready <= 1'b1;
            end

            // read position
            if (i_cfg.valid || i_cmd.op == cz_pkg::OP_CLEAR) begin
                r_rd_ptr <= '0;
                r_rd_row <= '0;
                r_rd_col <= '0;
            end else if (i_cmd.op == cz_pkg::OP_EMIT) begin
                if (rd_last) begin
                    r_rd_ptr <= '0;
                    r_rd_row <= '0;
                    r_rd_col <= '0;
                end else begin
                    r_rd_ptr <= ptr_nxt;
                    if (r_rd_col + KW'(1) == nc) begin
                        r_rd_col <= '0;
                        r_rd_row <= r_rd_row + CW'(1);
                    end else begin
                        r_rd_col <= r_rd_col + KW'(1);
                    end
                end
            end
        end
    end

    // status to the sequencer
    always_comb begin
        o_sts.in_mode     = i_in.mode;
        o_sts.in_valid    = i_in.valid;
        o_sts.rows_zero   = (div_q[CW-1:0] == '0);
        o_sts.stats_ready = r_stats_ready;
        o_sts.row_last    = (r_st_r + CW'(1) == r_rows);
        o_sts.col_last    = (r_st_c + KW'(1) == nc);
        o_sts.dev_zero    = (r_dev_rd == '0);
        o_sts.div_busy    = div_busy;
        o_sts.mul_busy    = r_m_busy;
        o_sts.sqrt_busy   = r_sq_busy;
        o_sts.out_free    = out_free;
    end

    // ports
    assign i_in.ready             = i_cmd.in_ready;
    assign i_cfg.ready            = 1'b1;
    assign o_out.valid            = r_out_valid;
    assign o_out.normalized_value = r_o_val;
    assign o_out.row_index        = r_o_row;
    assign o_out.column_index     = r_o_col;
    assign o_out.last             = r_o_last;
    assign o_out.status           = r_o_sts;

    // checks
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= cz_pkg::MAX_ELEM_CNT)
        else $error("load count beyond store depth");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == cz_pkg::OP_EMIT) |-> (r_rd_ptr < r_total))
        else $error("read pointer outside complete rows");

    a_stats_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stats_ready) |-> $past(i_cmd.op == cz_pkg::OP_COL_SAVE))
        else $error("statistics marked ready outside the column pass");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.mode == cz_pkg::MODE_READ) |=> (div_busy))
        else $error("read accepted without starting row count");

endmodule

@@ rtl/column_zscore_standardizer.sv @@
// Top level of the column z-score standardizer: sequencer plus datapath.
//
//  channel  dir  word                                                   accepted when
//  i_in     in   mode, sample_value                                     valid && ready
//  o_out    out  normalized_value, row_index, column_index, last, status valid && ready
//  i_cfg    in   num_columns                                            valid && ready
//
// A read steps through accept, 13-step row-count division and save, store and table
// read, setup, 24-step division by the column deviation and save, and result write;
// that division is skipped when the deviation is zero. The first read after a stored
// load, clear or config write adds the statistics pass: per column a store read and
// an accumulate for each row, then steps on the divider, multiplier and square root.
// Reset is synchronous, active low; the store is not cleared. A waiting result does not
// block the next input word; a read finishes only once the result register is free.
module column_zscore_standardizer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cz_in_if.sink    i_in,
    cz_out_if.source o_out,
    cz_cfg_if.sink   i_cfg
);
    cz_pkg::t_cmd cmd;
    cz_pkg::t_sts sts;

    cz_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cz_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule
